/* rtl/core/pcrbe_pkg.sv */
// Shared types and constants for the PCR bank with extend and reset.
`timescale 1ns / 1ps
package pcrbe_pkg;

  localparam int MAX_PCRS = 24;
  localparam int LOC_BITS = 5;

  // command ops
  localparam logic [1:0] OP_EXTEND = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_INDEX = 3'd1;
  localparam logic [2:0] ST_BAD_LOC   = 3'd2;
  localparam logic [2:0] ST_BAD_SEL   = 3'd3;
  localparam logic [2:0] ST_NOT_RES   = 3'd4;
  localparam logic [2:0] ST_NOT_LOCAL = 3'd5;

  // classified work kinds handed to the back end
  localparam logic [1:0] KIND_EXT = 2'd0;
  localparam logic [1:0] KIND_RD  = 2'd1;
  localparam logic [1:0] KIND_RST = 2'd2;
  localparam logic [1:0] KIND_ERR = 2'd3;

  // SHA-1 initial value and round constants
  localparam logic [159:0] SHA1_IV =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
  localparam logic [31:0] SHA1_K0 = 32'h5A827999;
  localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;
  localparam logic [31:0] SHA1_PAD = 32'h80000000;
  localparam logic [31:0] SHA1_LEN = 32'd320;

  typedef struct packed {
    logic [1:0]          kind;
    logic [2:0]          status;
    logic [4:0]          idx;
    logic [MAX_PCRS-1:0] rmask;
    logic [159:0]        digest;
  } pcrbe_cmd_t;

  typedef struct packed {
    logic [MAX_PCRS-1:0]          resettable;
    logic [MAX_PCRS*LOC_BITS-1:0] ext_loc;
    logic [MAX_PCRS*LOC_BITS-1:0] rst_loc;
    logic                         disabled;
  } pcrbe_cfg_t;

endpackage

/* rtl/core/pcrbe_if.sv */
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
interface pcrbe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  locality;
  logic [4:0]  pcr_index;
  logic [2:0]  select_bytes;
  logic [31:0] select_mask;
  logic [31:0] digest_top;
  logic [63:0] digest_middle;
  logic [63:0] digest_bottom;

  modport source (output valid, op, locality, pcr_index, select_bytes, select_mask,
                  digest_top, digest_middle, digest_bottom, input ready);
  modport sink (input valid, op, locality, pcr_index, select_bytes, select_mask,
                digest_top, digest_middle, digest_bottom, output ready);
endinterface

interface pcrbe_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] value_top;
  logic [63:0] value_middle;
  logic [63:0] value_bottom;

  modport source (output valid, status, value_top, value_middle, value_bottom,
                  input ready);
  modport sink (input valid, status, value_top, value_middle, value_bottom,
                output ready);
endinterface

/* rtl/core/pcrbe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pcrbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/pcrbe_front.sv */
// Front end: accepts commands, runs all checks, queues classified work.
`timescale 1ns / 1ps
module pcrbe_front #(
  parameter int PCR_COUNT = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  pcrbe_in_if.sink            in_ch,
  input  pcrbe_pkg::pcrbe_cfg_t cfg,
  input  logic                pop,
  output pcrbe_pkg::pcrbe_cmd_t head,
  output logic                head_valid
);
  import pcrbe_pkg::*;

  pcrbe_cmd_t          cls;
  logic                idx_ok;
  logic                loc_ok;
  logic                ext_ok;
  logic [7:0]          ext_bits;
  logic [5:0]          nsel;
  logic                sel_bad;
  logic [MAX_PCRS-1:0] win;
  logic [MAX_PCRS-1:0] fail4;
  logic [MAX_PCRS-1:0] fail5;
  logic [7:0]          rbits;
  logic [2:0]          rstat;

  pcrbe_cmd_t q_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  always_comb begin
    idx_ok   = in_ch.pcr_index < 5'(PCR_COUNT);
    loc_ok   = in_ch.locality <= 3'd4;
    ext_bits = {3'b000, cfg.ext_loc[in_ch.pcr_index * LOC_BITS +: LOC_BITS]};
    ext_ok   = loc_ok && ext_bits[in_ch.locality];
    nsel     = {in_ch.select_bytes, 3'b000};
    sel_bad  = nsel > 6'(PCR_COUNT);
    rbits    = '0;
    for (int i = 0; i < MAX_PCRS; i++) begin
      rbits    = {3'b000, cfg.rst_loc[i*LOC_BITS +: LOC_BITS]};
      win[i]   = (6'(i) < nsel) && (i < PCR_COUNT) && in_ch.select_mask[i];
      fail4[i] = win[i] && !cfg.resettable[i];
      fail5[i] = win[i] && cfg.resettable[i] && !(loc_ok && rbits[in_ch.locality]);
    end
    // lowest failing PCR wins
    rstat = ST_OK;
    for (int i = MAX_PCRS - 1; i >= 0; i--) begin
      if (fail4[i]) begin
        rstat = ST_NOT_RES;
      end else if (fail5[i]) begin
        rstat = ST_NOT_LOCAL;
      end
    end

    cls.idx    = in_ch.pcr_index;
    cls.rmask  = win;
    cls.digest = {in_ch.digest_top, in_ch.digest_middle, in_ch.digest_bottom};
    cls.kind   = KIND_ERR;
    cls.status = ST_OK;
    case (in_ch.op)
      OP_EXTEND: begin
        if (!idx_ok) begin
          cls.status = ST_BAD_INDEX;
        end else if (!ext_ok) begin
          cls.status = ST_BAD_LOC;
        end else begin
          cls.kind = KIND_EXT;
        end
      end
      OP_READ: begin
        if (!idx_ok) begin
          cls.status = ST_BAD_INDEX;
        end else begin
          cls.kind = KIND_RD;
        end
      end
      OP_RESET: begin
        if (sel_bad) begin
          cls.status = ST_BAD_SEL;
        end else if (rstat != ST_OK) begin
          cls.status = rstat;
        end else begin
          cls.kind = KIND_RST;
        end
      end
      default: cls.status = ST_BAD_SEL;
    endcase
  end

  // two-entry queue
  assign in_ch.ready = cnt_r != 2'd2;
  assign push        = in_ch.valid && in_ch.ready;
  assign head        = q_r[rd_ptr_r];
  assign head_valid  = cnt_r != 2'd0;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end
endmodule

/* rtl/core/pcrbe_back.sv */
// Back end: PCR storage, SHA-1 round engine and result register.
`timescale 1ns / 1ps
module pcrbe_back #(
  parameter int PCR_COUNT = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcrbe_pkg::pcrbe_cmd_t head,
  input  logic                  head_valid,
  input  logic                  disabled,
  output logic                  pop,
  pcrbe_out_if.source           out_ch
);
  import pcrbe_pkg::*;

  localparam int AW = $clog2(PCR_COUNT);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_ROUND = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]     state_r, state_nxt;
  pcrbe_cmd_t     cur_r;
  logic [PCR_COUNT-1:0] vld_r;
  logic [31:0]    a_r, b_r, c_r, d_r, e_r;
  logic [31:0]    wsh_r [16];
  logic [6:0]     rnd_r;
  logic           out_valid_r;
  logic [2:0]     out_status_r;
  logic [159:0]   out_value_r;

  logic           out_free;
  logic           out_load;
  logic [AW-1:0]  raddr;
  logic [159:0]   rdata;
  logic [159:0]   old_val;
  logic [159:0]   hash;
  logic           ram_we;
  logic [31:0]    f, k, t, wnew;

  assign out_free = !out_valid_r || out_ch.ready;
  assign raddr    = (state_r == S_IDLE) ? head.idx[AW-1:0] : cur_r.idx[AW-1:0];
  assign old_val  = vld_r[cur_r.idx[AW-1:0]] ? rdata : '0;
  assign hash     = {SHA1_IV[159:128] + a_r, SHA1_IV[127:96] + b_r,
                     SHA1_IV[95:64] + c_r, SHA1_IV[63:32] + d_r, SHA1_IV[31:0] + e_r};
  assign ram_we   = (state_r == S_FIN) && out_free;

  // result register is loaded only when it is free
  assign out_load = (state_r == S_IDLE && pop &&
                     (head.kind == KIND_RST || head.kind == KIND_ERR)) ||
                    (state_r == S_LOAD && cur_r.kind == KIND_RD && out_free) ||
                    ram_we;

  pcrbe_ram #(.WIDTH(160), .DEPTH(PCR_COUNT)) u_bank (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_r.idx[AW-1:0]),
    .wdata (hash),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = SHA1_K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = SHA1_K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = SHA1_K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = SHA1_K3;
    end
    t    = {a_r[26:0], a_r[31:27]} + f + e_r + k + wsh_r[0];
    wnew = wsh_r[13] ^ wsh_r[8] ^ wsh_r[2] ^ wsh_r[0];
    wnew = {wnew[30:0], wnew[31]};
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          if (head.kind == KIND_EXT || head.kind == KIND_RD) begin
            pop       = 1'b1;
            state_nxt = S_LOAD;
          end else if (out_free) begin
            pop = 1'b1;
          end
        end
      end
      S_LOAD: begin
        if (cur_r.kind == KIND_EXT) begin
          state_nxt = S_ROUND;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_ROUND: begin
        if (rnd_r == 7'd79) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE && pop && head.kind == KIND_RST) begin
        for (int i = 0; i < PCR_COUNT; i++) begin
          if (head.rmask[i]) begin
            vld_r[i] <= 1'b0;
          end
        end
      end
      if (ram_we) begin
        vld_r[cur_r.idx[AW-1:0]] <= 1'b1;
      end
    end

    if (pop) begin
      cur_r <= head;
    end
    if (out_load) begin
      out_status_r <= (state_r == S_IDLE) ? head.status : cur_r.status;
      if (state_r == S_LOAD) begin
        out_value_r <= old_val;
      end else if (state_r == S_FIN && !disabled) begin
        out_value_r <= hash;
      end else begin
        out_value_r <= '0;
      end
    end
    if (state_r == S_LOAD && cur_r.kind == KIND_EXT) begin
      {a_r, b_r, c_r, d_r, e_r} <= SHA1_IV;
      rnd_r <= '0;
      for (int j = 0; j < 5; j++) begin
        wsh_r[j] <= old_val[159 - 32*j -: 32];
        wsh_r[j+5] <= cur_r.digest[159 - 32*j -: 32];
      end
      wsh_r[10] <= SHA1_PAD;
      for (int j = 11; j < 15; j++) begin
        wsh_r[j] <= '0;
      end
      wsh_r[15] <= SHA1_LEN;
    end
    if (state_r == S_ROUND) begin
      a_r   <= t;
      b_r   <= a_r;
      c_r   <= {b_r[1:0], b_r[31:2]};
      d_r   <= c_r;
      e_r   <= d_r;
      rnd_r <= rnd_r + 7'd1;
      for (int j = 0; j < 15; j++) begin
        wsh_r[j] <= wsh_r[j+1];
      end
      wsh_r[15] <= wnew;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.value_top    = out_value_r[159:128];
  assign out_ch.value_middle = out_value_r[127:64];
  assign out_ch.value_bottom = out_value_r[63:0];
endmodule

/* rtl/core/pcr_bank_extend_reset_unit.sv */
// Top level: PCR bank with SHA-1 extend, read and atomic reset.
//
//  channel   dir   handshake              carries
//  in_ch     in    valid/ready            op, locality, index, selection, digest
//  out_ch    out   valid/ready            status, 160-bit PCR value
//  cfg_*     in    APB write, pready=1    six control registers at 8*i
//
// Extend in the back end: pop, bank read, 80 SHA-1 rounds at one
// round per cycle, write-back; the round engine is the limit.
// Read: pop, then bank read. Reset and rejected commands: handled at the pop.
// A two-entry queue sits after the checks, so commands keep arriving while
// the hash runs; the result register holds a result until out_ch takes it.
// rst_n (synchronous) empties the queue, clears the result and marks every
// PCR as zero through per-PCR valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
module pcr_bank_extend_reset_unit #(
  parameter int PCR_COUNT = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  pcrbe_in_if.sink    in_ch,
  pcrbe_out_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import pcrbe_pkg::*;

  // register map index (byte address / 8)
  localparam logic [2:0] REG_RESETTABLE = 3'd0;
  localparam logic [2:0] REG_EXT_LO     = 3'd1;
  localparam logic [2:0] REG_EXT_HI     = 3'd2;
  localparam logic [2:0] REG_RST_LO     = 3'd3;
  localparam logic [2:0] REG_RST_HI     = 3'd4;
  localparam logic [2:0] REG_DISABLED   = 3'd5;

  pcrbe_cfg_t cfg_r;
  pcrbe_cmd_t head;
  logic       head_valid;
  logic       pop;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.resettable <= '0;
      cfg_r.ext_loc    <= '1;
      cfg_r.rst_loc    <= '0;
      cfg_r.disabled   <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RESETTABLE: cfg_r.resettable     <= cfg_pwdata[23:0];
        REG_EXT_LO:     cfg_r.ext_loc[59:0]   <= cfg_pwdata[59:0];
        REG_EXT_HI:     cfg_r.ext_loc[119:60] <= cfg_pwdata[59:0];
        REG_RST_LO:     cfg_r.rst_loc[59:0]   <= cfg_pwdata[59:0];
        REG_RST_HI:     cfg_r.rst_loc[119:60] <= cfg_pwdata[59:0];
        REG_DISABLED:   cfg_r.disabled       <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RESETTABLE: cfg_prdata = {40'd0, cfg_r.resettable};
      REG_EXT_LO:     cfg_prdata = {4'd0, cfg_r.ext_loc[59:0]};
      REG_EXT_HI:     cfg_prdata = {4'd0, cfg_r.ext_loc[119:60]};
      REG_RST_LO:     cfg_prdata = {4'd0, cfg_r.rst_loc[59:0]};
      REG_RST_HI:     cfg_prdata = {4'd0, cfg_r.rst_loc[119:60]};
      REG_DISABLED:   cfg_prdata = {63'd0, cfg_r.disabled};
      default:        cfg_prdata = '0;
    endcase
  end

  // checks and queue
  pcrbe_front #(.PCR_COUNT(PCR_COUNT)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // storage, hash and result register
  pcrbe_back #(.PCR_COUNT(PCR_COUNT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .disabled   (cfg_r.disabled),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  // an error result never carries a value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |->
      out_ch.value_top == '0 && out_ch.value_middle == '0 && out_ch.value_bottom == '0)
    else $error("error result with nonzero value");

  // reset leaves no result pending and the queue open
  a_rst_clean: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && in_ch.ready)
    else $error("state left after reset");

  // the queue is only popped when it holds work
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");
endmodule

/* verif/tb.sv */
// Self-checking testbench for the PCR bank with SHA-1 extend, read and reset.
`timescale 1ns / 1ps
module tb;
  import pcrbe_pkg::*;

  localparam int NPCR = 24;
  localparam logic [59:0] ALL60 = {60{1'b1}};

  // register indexes, byte address is 8*index
  localparam int REG_RESETTABLE = 0;
  localparam int REG_EXT_LOC_LO = 1;
  localparam int REG_EXT_LOC_HI = 2;
  localparam int REG_RST_LOC_LO = 3;
  localparam int REG_RST_LOC_HI = 4;
  localparam int REG_DISABLED   = 5;

  typedef struct packed {
    logic [1:0]   op;
    logic [2:0]   locality;
    logic [4:0]   pcr_index;
    logic [2:0]   select_bytes;
    logic [31:0]  select_mask;
    logic [159:0] digest;   // {top, middle, bottom}
  } pcr_cmd_t;

  typedef struct packed {
    logic [2:0]   status;
    logic [159:0] value;
  } pcr_result_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  pcrbe_in_if  in_ch();
  pcrbe_out_if out_ch();

  pcr_bank_extend_reset_unit #(.PCR_COUNT(NPCR)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // shadow of the block: PCR contents and control registers
  logic [159:0] pcr_bank [NPCR];
  logic [23:0]  sh_resettable;
  logic [119:0] sh_ext_loc;   // {high, low}: bit 5*pcr + locality
  logic [119:0] sh_rst_loc;
  logic         sh_disabled;

  pcr_cmd_t    cmds_pending[$];
  pcr_result_t results_due[$];
  int errors = 0;

  // pacing knobs set by the stimulus thread; the monitor clears hold_req
  bit no_idle = 0;
  bit hold_req = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL pcr_bank_extend_reset_unit");
    $finish;
  end

  task automatic report(input string what, input logic [159:0] got, input logic [159:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // one padded block: 40 message bytes, pad byte, bit length 320
  function automatic logic [159:0] sha1_extend(input logic [159:0] old, input logic [159:0] dig);
    logic [31:0] w [80];
    logic [319:0] msg;
    logic [31:0] a, b, c, d, e, f, k, t;
    msg = {old, dig};
    for (int i = 0; i < 10; i++) w[i] = msg[319-32*i -: 32];
    w[10] = SHA1_PAD;
    for (int i = 11; i < 15; i++) w[i] = '0;
    w[15] = SHA1_LEN;
    for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    {a, b, c, d, e} = SHA1_IV;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = SHA1_K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = SHA1_K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = SHA1_K2;
      end else begin
        f = b ^ c ^ d; k = SHA1_K3;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    return {SHA1_IV[159:128] + a, SHA1_IV[127:96] + b, SHA1_IV[95:64] + c,
            SHA1_IV[63:32] + d, SHA1_IV[31:0] + e};
  endfunction

  function automatic bit loc_ok(input logic [119:0] allow, input int pcr, input logic [2:0] loc);
    if (loc > 4) return 0;
    return allow[5*pcr + loc];
  endfunction

  // expected result of one command; updates the shadow bank
  function automatic pcr_result_t apply_command(input pcr_cmd_t c);
    pcr_result_t r;
    int n;
    r.status = ST_OK;
    r.value = '0;
    if (c.op == OP_EXTEND || c.op == OP_READ) begin
      if (c.pcr_index >= NPCR) r.status = ST_BAD_INDEX;
      else if (c.op == OP_READ) r.value = pcr_bank[c.pcr_index];
      else if (!loc_ok(sh_ext_loc, c.pcr_index, c.locality)) r.status = ST_BAD_LOC;
      else begin
        pcr_bank[c.pcr_index] = sha1_extend(pcr_bank[c.pcr_index], c.digest);
        if (!sh_disabled) r.value = pcr_bank[c.pcr_index];
      end
    end else if (c.op == OP_RESET) begin
      n = c.select_bytes * 8;
      if (n > NPCR) r.status = ST_BAD_SEL;
      else begin
        // all-or-nothing: first failing PCR in index order decides
        for (int i = 0; i < n && r.status == ST_OK; i++) begin
          if (!c.select_mask[i]) continue;
          if (!sh_resettable[i]) r.status = ST_NOT_RES;
          else if (!loc_ok(sh_rst_loc, i, c.locality)) r.status = ST_NOT_LOCAL;
        end
        if (r.status == ST_OK)
          for (int i = 0; i < n; i++) if (c.select_mask[i]) pcr_bank[i] = '0;
      end
    end else r.status = ST_BAD_SEL;  // unused op
    return r;
  endfunction

  // ---------------- command driver ----------------
  int send_gap = 0;
  pcr_cmd_t nxt;
  bit took;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        results_due.push_back(apply_command(cmds_pending.pop_front()));
        send_gap = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (in_ch.valid && !took) begin
        // holding the current item until the block takes it
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (cmds_pending.size() > (took ? 0 : 0)) begin
        nxt = cmds_pending[0];
        in_ch.valid <= 1'b1;
        in_ch.op <= nxt.op;
        in_ch.locality <= nxt.locality;
        in_ch.pcr_index <= nxt.pcr_index;
        in_ch.select_bytes <= nxt.select_bytes;
        in_ch.select_mask <= nxt.select_mask;
        {in_ch.digest_top, in_ch.digest_middle, in_ch.digest_bottom} <= nxt.digest;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------- result monitor ----------------
  int recv_stall = 0;
  int hold_left = 0;
  pcr_result_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          report("unexpected result", {out_ch.value_top, out_ch.value_middle,
                 out_ch.value_bottom}, '0);
        end else begin
          want = results_due.pop_front();
          if (out_ch.status !== want.status) report("status", out_ch.status, want.status);
          if (out_ch.value_top !== want.value[159:128])
            report("value_top", out_ch.value_top, want.value[159:128]);
          if (out_ch.value_middle !== want.value[127:64])
            report("value_middle", out_ch.value_middle, want.value[127:64]);
          if (out_ch.value_bottom !== want.value[63:0])
            report("value_bottom", out_ch.value_bottom, want.value[63:0]);
        end
        recv_stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (hold_left == 0 && hold_req) begin
        // long back-pressure so the internal queue fills and in_ch stalls
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- configuration port ----------------
  task automatic cfg_write(input int idx, input logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= 6'(idx * 8); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_RESETTABLE: sh_resettable = val[23:0];
      REG_EXT_LOC_LO: sh_ext_loc[59:0] = val[59:0];
      REG_EXT_LOC_HI: sh_ext_loc[119:60] = val[59:0];
      REG_RST_LOC_LO: sh_rst_loc[59:0] = val[59:0];
      REG_RST_LOC_HI: sh_rst_loc[119:60] = val[59:0];
      default: sh_disabled = val[0];
    endcase
  endtask

  task automatic write_all(input logic [23:0] res, input logic [119:0] ext,
                           input logic [119:0] rst, input bit dis);
    cfg_write(REG_RESETTABLE, {40'b0, res});
    cfg_write(REG_EXT_LOC_LO, {4'b0, ext[59:0]});
    cfg_write(REG_EXT_LOC_HI, {4'b0, ext[119:60]});
    cfg_write(REG_RST_LOC_LO, {4'b0, rst[59:0]});
    cfg_write(REG_RST_LOC_HI, {4'b0, rst[119:60]});
    cfg_write(REG_DISABLED, {63'b0, dis});
  endtask

  // wait until every result is back, then let an extend's worth of cycles pass
  task automatic drain();
    do @(posedge clk);
    while (cmds_pending.size() != 0 || in_ch.valid || results_due.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic pcr_cmd_t mk(input logic [1:0] op, input logic [2:0] loc,
                                  input logic [4:0] idx, input logic [2:0] nb,
                                  input logic [31:0] sel, input logic [159:0] dig);
    pcr_cmd_t c;
    c.op = op; c.locality = loc; c.pcr_index = idx;
    c.select_bytes = nb; c.select_mask = sel; c.digest = dig;
    return c;
  endfunction

  function automatic logic [159:0] rand160();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [59:0] rand60();
    return 60'({$urandom, $urandom});
  endfunction

  // mostly legal commands with random content; some raw noise
  function automatic pcr_cmd_t rand_cmd();
    pcr_cmd_t c;
    int pick;
    c.op = 2'($urandom);
    c.locality = 3'($urandom);
    c.pcr_index = 5'($urandom);
    c.select_bytes = 3'($urandom);
    c.select_mask = $urandom;
    c.digest = rand160();
    if ($urandom_range(0, 9) == 0) return c;
    pick = $urandom_range(0, 9);
    c.op = pick < 6 ? OP_EXTEND : (pick < 8 ? OP_READ : OP_RESET);
    c.locality = 3'($urandom_range(0, 4));
    c.pcr_index = 5'($urandom_range(0, NPCR - 1));
    c.select_bytes = 3'($urandom_range(0, 3));
    if ($urandom_range(0, 1)) c.select_mask = $urandom & $urandom & $urandom;
    return c;
  endfunction

  initial begin
    logic [119:0] ext_cfg, rst_cfg;
    in_ch.valid = 0; in_ch.op = '0; in_ch.locality = '0; in_ch.pcr_index = '0;
    in_ch.select_bytes = '0; in_ch.select_mask = '0; in_ch.digest_top = '0;
    in_ch.digest_middle = '0; in_ch.digest_bottom = '0;
    out_ch.ready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    for (int i = 0; i < NPCR; i++) pcr_bank[i] = '0;
    sh_resettable = '0; sh_ext_loc = '1; sh_rst_loc = '0; sh_disabled = 0;

    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // directed, reset defaults: extend anything, reset nothing
    cmds_pending.push_back(mk(OP_READ, 0, 0, 0, 0, '0));          // zero after reset
    cmds_pending.push_back(mk(OP_EXTEND, 0, 0, 0, 0, '0));
    cmds_pending.push_back(mk(OP_EXTEND, 4, 23, 0, 0, '1));       // top PCR, all-ones digest
    cmds_pending.push_back(mk(OP_READ, 7, 23, 0, 0, '0));         // read ignores locality
    cmds_pending.push_back(mk(OP_EXTEND, 0, 24, 0, 0, '0));       // index just past range
    cmds_pending.push_back(mk(OP_READ, 0, 31, 0, 0, '0));
    cmds_pending.push_back(mk(OP_EXTEND, 5, 3, 0, 0, rand160()));  // locality above four
    cmds_pending.push_back(mk(OP_EXTEND, 7, 3, 0, 0, rand160()));
    cmds_pending.push_back(mk(2'd3, 0, 0, 0, 0, '0));              // unused op
    cmds_pending.push_back(mk(OP_RESET, 0, 0, 4, '1, '0));         // selection too long
    cmds_pending.push_back(mk(OP_RESET, 0, 0, 0, '1, '0));         // empty selection
    cmds_pending.push_back(mk(OP_RESET, 0, 0, 1, 32'h1, '0));      // not resettable
    drain();

    write_all('1, '0, {120{1'b1}}, 1);
    cmds_pending.push_back(mk(OP_EXTEND, 1, 5, 0, 0, rand160()));  // no extend locality
    cmds_pending.push_back(mk(OP_READ, 0, 0, 0, 0, '0));
    cmds_pending.push_back(mk(OP_RESET, 7, 0, 3, '1, '0));         // not local
    cmds_pending.push_back(mk(OP_RESET, 2, 0, 3, 32'hFF000001, '0)); // bits beyond ignored
    cmds_pending.push_back(mk(OP_READ, 0, 0, 0, 0, '0));
    cmds_pending.push_back(mk(OP_READ, 0, 23, 0, 0, '0));
    drain();
    cfg_write(REG_EXT_LOC_LO, {4'b0, ALL60});
    cmds_pending.push_back(mk(OP_EXTEND, 2, 5, 0, 0, rand160()));  // disabled extend
    cmds_pending.push_back(mk(OP_READ, 2, 5, 0, 0, '0));
    cmds_pending.push_back(mk(OP_RESET, 0, 5, 1, 32'h00000020, '0));
    cmds_pending.push_back(mk(OP_READ, 2, 5, 0, 0, '0));
    drain();

    // random phases under changing settings
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        write_all('0, '0, '0, 0);
      end else if (ph == 1) begin
        write_all('1, {120{1'b1}}, {120{1'b1}}, 0);
      end else begin
        ext_cfg = {rand60() | rand60(), rand60() | rand60()};
        rst_cfg = {rand60() | rand60(), rand60() | rand60()};
        write_all(24'($urandom | $urandom), ext_cfg, rst_cfg, $urandom_range(0, 3) == 0);
      end
      no_idle = (ph % 4 == 2);
      for (int i = 0; i < 103; i++) cmds_pending.push_back(rand_cmd());
      if (ph == 3) hold_req = 1;
      drain();
    end

    if (errors == 0) $display("PASS pcr_bank_extend_reset_unit");
    else $display("FAIL pcr_bank_extend_reset_unit");
    $finish;
  end

endmodule
